FILE: hdl/langevin_lattice_site_update_macros.svh
// Assertion macros for the lattice site update block.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef LANGEVIN_LATTICE_SITE_UPDATE_MACROS_SVH
`define LANGEVIN_LATTICE_SITE_UPDATE_MACROS_SVH

// Same-cycle implication.
`define LLSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lattice site update check failed");

// Next-cycle implication.
`define LLSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lattice site update check failed");

`endif

FILE: hdl/llsu_pkg.sv
// Package for the lattice site update block: constants, register codes, types
// and fixed-point helper functions. No dependencies.
`default_nettype none
package llsu_pkg;

    localparam int LATTICE_DEF  = 32;
    localparam int TWO_PI_Q     = 411775;
    localparam int PI_Q         = 205887;
    localparam int HALF_PI_Q    = 102944;
    localparam int CORDIC_K     = 39797;
    localparam int ONE_Q        = 65536;
    localparam int RED_STEPS    = 15;
    localparam int CORDIC_STEPS = 16;

    // offset that makes any 33-bit angle difference positive, a multiple of 2pi
    localparam logic [33:0] ANGLE_OFFSET = 34'(64'(TWO_PI_Q) << 14);

    localparam logic       CMD_LOAD   = 1'b0;
    localparam logic       CMD_UPDATE = 1'b1;

    localparam logic [30:0]        DAMPING_RST    = 31'd327680;
    localparam logic [16:0]        TIME_STEP_RST  = 17'd655;
    localparam logic [30:0]        NOISE_GAIN_RST = 31'd2072;
    localparam logic signed [31:0] WELL_STR_RST   = 32'sd65536;
    localparam logic signed [31:0] WELL_DEP_RST   = 32'sd655360;
    localparam logic signed [31:0] COUPLING_RST   = 32'sd655360;
    localparam logic [30:0]        INV_RAMP_RST   = 31'd6554;
    localparam logic signed [31:0] START_TIME_RST = -32'sd655360;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

    typedef enum logic [2:0] {
        REG_DAMPING,
        REG_TIME_STEP,
        REG_NOISE_GAIN,
        REG_WELL_STRENGTH,
        REG_WELL_DEPTH,
        REG_COUPLING,
        REG_INV_RAMP_TIME,
        REG_START_TIME
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cordic_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) r = 32'sh7fff_ffff;
        else if (v < SAT_MIN) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // floor shift of a Q32.32 product back to Q16.16, then saturate
    function automatic logic signed [31:0] qfin(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        return sat32(s);
    endfunction

    function automatic logic [33:0] red_step(input logic [33:0] u, input int j);
        logic [33:0] m;
        m = 34'(TWO_PI_Q) << j;
        return (u >= m) ? (u - m) : u;
    endfunction

    // map [0, 2pi) into [-pi/2, pi/2] with the same sine
    function automatic logic signed [31:0] fold_angle(input logic [33:0] r);
        logic signed [31:0] a;
        a = $signed(r[31:0]);
        if (a > PI_Q) a = a - TWO_PI_Q;
        if (a > HALF_PI_Q) a = PI_Q - a;
        else if (a < -HALF_PI_Q) a = -PI_Q - a;
        return a;
    endfunction

    function automatic logic signed [31:0] atan_q(input int i);
        logic signed [31:0] r;
        case (i)
            0:  r = 32'sd51472;
            1:  r = 32'sd30385;
            2:  r = 32'sd16055;
            3:  r = 32'sd8150;
            4:  r = 32'sd4091;
            5:  r = 32'sd2047;
            6:  r = 32'sd1024;
            7:  r = 32'sd512;
            8:  r = 32'sd256;
            9:  r = 32'sd128;
            10: r = 32'sd64;
            11: r = 32'sd32;
            12: r = 32'sd16;
            13: r = 32'sd8;
            14: r = 32'sd4;
            15: r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t n;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (!c.z[31]) begin
            n.x = c.x - ys;
            n.y = c.y + xs;
            n.z = c.z - atan_q(i);
        end else begin
            n.x = c.x + ys;
            n.y = c.y - xs;
            n.z = c.z + atan_q(i);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/langevin_lattice_site_update.sv
// An update's result is registered at the output as its item leaves the pipeline; a load
// gives no result and is written to the stores at the end of the pipeline. Throughput: one
// item per cycle while the output is not stalled. An update waits while a load or the last
// site of a sweep is still in the pipeline, until its store write. Reset: clears control,
// sweep position and bank select; configuration registers take their reset values and
// sim_time the start_time reset value. Stores are undefined until written.
`default_nettype none
`include "langevin_lattice_site_update_macros.svh"
module langevin_lattice_site_update #(
    parameter int LATTICE = llsu_pkg::LATTICE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // item channel
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               cmd,
    input  wire logic [4:0]         site_row,
    input  wire logic [4:0]         site_col,
    input  wire logic signed [31:0] load_position,
    input  wire logic signed [31:0] load_velocity,
    input  wire logic signed [15:0] noise,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic      [4:0]         out_row,
    output logic      [4:0]         out_col,
    output logic signed [31:0]      new_position,
    output logic signed [31:0]      new_velocity,
    output logic signed [31:0]      step_time,
    output logic                    sweep_last
);

    localparam int LW     = (LATTICE > 1) ? $clog2(LATTICE) : 1;
    localparam int AW     = $clog2(LATTICE * LATTICE);
    localparam int PDEPTH = 2 ** (AW + 1);
    localparam int VDEPTH = 2 ** AW;
    localparam int NST    = 20;   // pipeline stages S1..S20, S20 writes the stores
    localparam int RED_ST = 5;    // angle reduction stages
    localparam int RED_PER = llsu_pkg::RED_STEPS / RED_ST;
    localparam int COR_ST = 8;    // CORDIC stages
    localparam int COR_PER = llsu_pkg::CORDIC_STEPS / COR_ST;

    // Per-item payload carried down the pipeline. Loads park their write values in
    // nq and v so the single write stage at the end serves both commands.
    typedef struct packed {
        logic               upd;
        logic               last;
        logic [LW-1:0]      row;
        logic [LW-1:0]      col;
        logic [AW-1:0]      addr;
        logic               wbank;
        logic signed [15:0] noise;
        logic signed [31:0] used;
        logic signed [31:0] q;
        logic signed [31:0] nq;
        logic signed [31:0] v;
        logic signed [31:0] damp;
        logic signed [31:0] nt;
        logic signed [31:0] onsite;
    } carry_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0]        damping_reg;
    logic [16:0]        time_step_reg;
    logic [30:0]        noise_gain_reg;
    logic signed [31:0] well_strength_reg;
    logic signed [31:0] well_depth_reg;
    logic signed [31:0] coupling_reg;
    logic [30:0]        inv_ramp_reg;
    logic signed [31:0] start_time_reg;

    logic                 cfg_wr;
    llsu_pkg::reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = llsu_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg       <= llsu_pkg::DAMPING_RST;
            time_step_reg     <= llsu_pkg::TIME_STEP_RST;
            noise_gain_reg    <= llsu_pkg::NOISE_GAIN_RST;
            well_strength_reg <= llsu_pkg::WELL_STR_RST;
            well_depth_reg    <= llsu_pkg::WELL_DEP_RST;
            coupling_reg      <= llsu_pkg::COUPLING_RST;
            inv_ramp_reg      <= llsu_pkg::INV_RAMP_RST;
            start_time_reg    <= llsu_pkg::START_TIME_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                llsu_pkg::REG_DAMPING:       damping_reg       <= pwdata[30:0];
                llsu_pkg::REG_TIME_STEP:     time_step_reg     <= pwdata[16:0];
                llsu_pkg::REG_NOISE_GAIN:    noise_gain_reg    <= pwdata[30:0];
                llsu_pkg::REG_WELL_STRENGTH: well_strength_reg <= $signed(pwdata);
                llsu_pkg::REG_WELL_DEPTH:    well_depth_reg    <= $signed(pwdata);
                llsu_pkg::REG_COUPLING:      coupling_reg      <= $signed(pwdata);
                llsu_pkg::REG_INV_RAMP_TIME: inv_ramp_reg      <= pwdata[30:0];
                llsu_pkg::REG_START_TIME:    start_time_reg    <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            llsu_pkg::REG_DAMPING:       prdata = {1'b0, damping_reg};
            llsu_pkg::REG_TIME_STEP:     prdata = {15'b0, time_step_reg};
            llsu_pkg::REG_NOISE_GAIN:    prdata = {1'b0, noise_gain_reg};
            llsu_pkg::REG_WELL_STRENGTH: prdata = well_strength_reg;
            llsu_pkg::REG_WELL_DEPTH:    prdata = well_depth_reg;
            llsu_pkg::REG_COUPLING:      prdata = coupling_reg;
            llsu_pkg::REG_INV_RAMP_TIME: prdata = {1'b0, inv_ramp_reg};
            llsu_pkg::REG_START_TIME:    prdata = start_time_reg;
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and interlock
    // ------------------------------------------------------------------
    logic            result_valid_reg;
    logic [NST:1]    vld_reg;
    carry_t          pipe_reg [1:NST];
    logic [NST:1]    haz;
    logic            haz_any;
    logic            haz_older;
    logic            adv;
    logic            acc;

    // advance the whole pipeline unless a result sits in the output register unread
    assign adv = !result_valid_reg || !result_stall;

    // loads and last-of-sweep updates change what later updates read; hold any update
    // behind them until they have written the stores
    always_comb
    begin
        for (int i = 1; i <= NST; i++)
            haz[i] = vld_reg[i] && (!pipe_reg[i].upd || pipe_reg[i].last);
    end
    assign haz_any   = |haz;
    assign haz_older = |haz[NST:2];

    assign item_stall = !adv || ((cmd == llsu_pkg::CMD_UPDATE) && haz_any);
    assign acc        = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // Sweep position, bank select, simulation time
    // ------------------------------------------------------------------
    logic               bank_select_reg;
    logic [LW-1:0]      sweep_row_reg;
    logic [LW-1:0]      sweep_col_reg;
    logic signed [31:0] sim_time_reg;
    logic signed [31:0] sim_time_next;
    logic [LW-1:0]      row_right_col;
    logic [LW-1:0]      down_row;
    logic               at_last_col;
    logic               at_last_row;
    logic               in_range;
    logic [AW-1:0]      rd_k;
    logic [AW-1:0]      rd_r;
    logic [AW-1:0]      rd_d;
    carry_t             entry;

    assign at_last_col   = (sweep_col_reg == LW'(LATTICE - 1));
    assign at_last_row   = (sweep_row_reg == LW'(LATTICE - 1));
    assign row_right_col = at_last_col ? '0 : sweep_col_reg + 1'b1;
    assign down_row      = at_last_row ? '0 : sweep_row_reg + 1'b1;
    assign rd_k = AW'(32'(sweep_row_reg) * LATTICE + 32'(sweep_col_reg));
    assign rd_r = AW'(32'(sweep_row_reg) * LATTICE + 32'(row_right_col));
    assign rd_d = AW'(32'(down_row) * LATTICE + 32'(sweep_col_reg));
    assign in_range = (32'(site_row) < 32'(LATTICE)) && (32'(site_col) < 32'(LATTICE));
    assign sim_time_next = llsu_pkg::sat32(64'(sim_time_reg) + 64'(time_step_reg));

    always_comb
    begin
        entry        = '0;
        entry.upd    = (cmd == llsu_pkg::CMD_UPDATE);
        entry.noise  = noise;
        entry.used   = sim_time_reg;
        entry.nq     = load_position;
        entry.v      = load_velocity;
        if (cmd == llsu_pkg::CMD_UPDATE)
        begin
            entry.row   = sweep_row_reg;
            entry.col   = sweep_col_reg;
            entry.addr  = rd_k;
            entry.last  = at_last_row && at_last_col;
            entry.wbank = ~bank_select_reg;
        end
        else
        begin
            entry.row   = LW'(site_row);
            entry.col   = LW'(site_col);
            entry.addr  = AW'(32'(LW'(site_row)) * LATTICE + 32'(LW'(site_col)));
            entry.wbank = bank_select_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= 1'b0;
            sweep_row_reg   <= '0;
            sweep_col_reg   <= '0;
            sim_time_reg    <= llsu_pkg::START_TIME_RST;
        end
        else
        begin
            if (cfg_wr && (cfg_idx == llsu_pkg::REG_START_TIME))
                sim_time_reg <= $signed(pwdata);
            else if (acc && entry.upd && entry.last)
                sim_time_reg <= sim_time_next;

            if (acc && entry.upd)
            begin
                // advance raster order; swap banks at the end of a sweep
                sweep_col_reg <= row_right_col;
                if (at_last_col)
                    sweep_row_reg <= down_row;
                if (entry.last)
                    bank_select_reg <= ~bank_select_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stores: three position replicas (site, right, down reads) and velocity
    // ------------------------------------------------------------------
    logic signed [31:0] pos_a_mem [0:PDEPTH-1];
    logic signed [31:0] pos_b_mem [0:PDEPTH-1];
    logic signed [31:0] pos_c_mem [0:PDEPTH-1];
    logic signed [31:0] vel_mem   [0:VDEPTH-1];
    logic signed [31:0] q_rd_reg;
    logic signed [31:0] qr_rd_reg;
    logic signed [31:0] qd_rd_reg;
    logic signed [31:0] v_rd_reg;

    logic               wr_en;
    logic [AW:0]        wr_paddr;
    logic signed [31:0] wr_pos;
    logic signed [31:0] wr_vel;
    logic signed [31:0] s20_nv;

    assign wr_en    = adv && vld_reg[NST];
    assign wr_paddr = {pipe_reg[NST].wbank, pipe_reg[NST].addr};
    assign wr_pos   = pipe_reg[NST].nq;
    assign wr_vel   = pipe_reg[NST].upd ? s20_nv : pipe_reg[NST].v;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_a_mem[wr_paddr]            <= wr_pos;
            pos_b_mem[wr_paddr]            <= wr_pos;
            pos_c_mem[wr_paddr]            <= wr_pos;
            vel_mem[pipe_reg[NST].addr]    <= wr_vel;
        end
        if (adv)
        begin
            q_rd_reg  <= pos_a_mem[{bank_select_reg, rd_k}];
            qr_rd_reg <= pos_b_mem[{bank_select_reg, rd_r}];
            qd_rd_reg <= pos_c_mem[{bank_select_reg, rd_d}];
            v_rd_reg  <= vel_mem[rd_k];
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [63:0] p_qq_reg, p_eps_reg, p_dmp_reg, p_qv_reg, p_nz_reg;
    logic signed [63:0] p_cube_reg, p_wde_reg, p_t_reg, p_on_reg, p_c_reg, p_f_reg;
    logic signed [31:0] cube_reg, inner_reg, sines_reg, force_reg;
    logic [33:0]        red_reg [0:RED_ST][0:1];
    logic [33:0]        red_next [0:RED_ST-1][0:1];
    llsu_pkg::cordic_t  cor_reg [0:COR_ST][0:1];
    llsu_pkg::cordic_t  cor_next [0:COR_ST-1][0:1];
    llsu_pkg::cordic_t  cor_init [0:1];
    carry_t             pipe_next [1:NST];

    logic signed [31:0] s1_used, s1_inv, s1_damping, s1_dt, s1_gain;
    logic signed [15:0] s1_noise;
    logic signed [32:0] s1_a1, s1_a2;
    logic signed [63:0] s1_qq, s1_eps, s1_dmp, s1_qv, s1_nz;
    logic signed [31:0] s2_qq, s2_eps_raw, s2_eps, s2_nq, s2_damp, s2_nt, s2_q;
    logic signed [63:0] s2_cube, s2_wde, s2_nzs;
    logic signed [31:0] s3_cube, s3_wde, s3_q;
    logic signed [63:0] s3_t;
    logic signed [31:0] s4_t, s4_inner;
    logic signed [63:0] s5_on;
    logic signed [31:0] s6_on, s16_sines, s18_coup, s18_force, s19_dt;
    logic signed [63:0] s17_c, s19_f;

    always_comb
    begin
        // S1: first products and angle differences
        s1_used    = pipe_reg[1].used;
        s1_noise   = pipe_reg[1].noise;
        s1_inv     = $signed({1'b0, inv_ramp_reg});
        s1_damping = $signed({1'b0, damping_reg});
        s1_dt      = $signed({15'b0, time_step_reg});
        s1_gain    = $signed({1'b0, noise_gain_reg});
        s1_qq      = q_rd_reg * q_rd_reg;
        s1_eps     = s1_used * s1_inv;
        s1_dmp     = s1_damping * v_rd_reg;
        s1_qv      = v_rd_reg * s1_dt;
        s1_nz      = s1_noise * s1_gain;
        s1_a1      = q_rd_reg - qr_rd_reg;
        s1_a2      = q_rd_reg - qd_rd_reg;

        // S2: ramp factor, position step, damping and noise terms
        s2_q       = pipe_reg[2].q;
        s2_qq      = llsu_pkg::qfin(p_qq_reg);
        s2_eps_raw = llsu_pkg::qfin(p_eps_reg);
        s2_eps     = (s2_eps_raw > llsu_pkg::ONE_Q) ? 32'(llsu_pkg::ONE_Q) : s2_eps_raw;
        s2_nq      = llsu_pkg::sat32(64'(s2_q) + 64'(llsu_pkg::qfin(p_qv_reg)));
        s2_damp    = llsu_pkg::qfin(p_dmp_reg);
        s2_nzs     = p_nz_reg >>> 12;
        s2_nt      = llsu_pkg::sat32(s2_nzs);
        s2_cube    = s2_qq * s2_q;
        s2_wde     = well_depth_reg * s2_eps;

        // S3, S4: onsite inner term
        s3_q       = pipe_reg[3].q;
        s3_cube    = llsu_pkg::qfin(p_cube_reg);
        s3_wde     = llsu_pkg::qfin(p_wde_reg);
        s3_t       = s3_wde * s3_q;
        s4_t       = llsu_pkg::qfin(p_t_reg);
        s4_inner   = llsu_pkg::sat32(64'(cube_reg) + 64'(cube_reg) - 64'(s4_t));

        // S5, S6: onsite force
        s5_on      = well_strength_reg * inner_reg;
        s6_on      = llsu_pkg::qfin(p_on_reg);

        // S16..S20: coupling, total force, velocity step
        s16_sines  = llsu_pkg::sat32(64'(cor_reg[COR_ST][0].y) + 64'(cor_reg[COR_ST][1].y));
        s17_c      = coupling_reg * sines_reg;
        s18_coup   = llsu_pkg::qfin(p_c_reg);
        s18_force  = llsu_pkg::sat32(-64'(pipe_reg[18].damp) - 64'(pipe_reg[18].onsite)
                                     - 64'(s18_coup));
        s19_dt     = $signed({15'b0, time_step_reg});
        s19_f      = force_reg * s19_dt;
        s20_nv     = llsu_pkg::sat32(64'(pipe_reg[NST].v) + 64'(llsu_pkg::qfin(p_f_reg))
                                     + 64'(pipe_reg[NST].nt));
    end

    // shift the payload one stage; values computed along the way replace the carried copy
    always_comb
    begin
        pipe_next[1] = entry;
        for (int i = 2; i <= NST; i++)
            pipe_next[i] = pipe_reg[i-1];
        pipe_next[2].q = q_rd_reg;
        if (pipe_reg[1].upd)
            pipe_next[2].v = v_rd_reg;
        if (pipe_reg[2].upd)
            pipe_next[3].nq = s2_nq;
        pipe_next[3].damp   = s2_damp;
        pipe_next[3].nt     = s2_nt;
        pipe_next[7].onsite = s6_on;
    end

    // angle reduction, RED_PER (three) compare-subtract steps per stage
    always_comb
    begin
        logic [33:0] t;
        for (int s = 0; s < RED_ST; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                t = red_reg[s][l];
                for (int m = 0; m < RED_PER; m++)
                    t = llsu_pkg::red_step(t, llsu_pkg::RED_STEPS - 1 - RED_PER * s - m);
                red_next[s][l] = t;
            end
        end
    end

    // CORDIC rotations
    always_comb
    begin
        llsu_pkg::cordic_t c;
        for (int l = 0; l < 2; l++)
        begin
            cor_init[l].x = 32'(llsu_pkg::CORDIC_K);
            cor_init[l].y = '0;
            cor_init[l].z = llsu_pkg::fold_angle(red_reg[RED_ST][l]);
        end
        for (int s = 0; s < COR_ST; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                c = cor_reg[s][l];
                for (int m = 0; m < COR_PER; m++)
                    c = llsu_pkg::cordic_step(c, COR_PER * s + m);
                cor_next[s][l] = c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= NST; i++)
                pipe_reg[i] <= pipe_next[i];

            p_qq_reg   <= s1_qq;
            p_eps_reg  <= s1_eps;
            p_dmp_reg  <= s1_dmp;
            p_qv_reg   <= s1_qv;
            p_nz_reg   <= s1_nz;
            p_cube_reg <= s2_cube;
            p_wde_reg  <= s2_wde;
            cube_reg   <= s3_cube;
            p_t_reg    <= s3_t;
            inner_reg  <= s4_inner;
            p_on_reg   <= s5_on;
            sines_reg  <= s16_sines;
            p_c_reg    <= s17_c;
            force_reg  <= s18_force;
            p_f_reg    <= s19_f;

            red_reg[0][0] <= llsu_pkg::ANGLE_OFFSET + 34'(s1_a1);
            red_reg[0][1] <= llsu_pkg::ANGLE_OFFSET + 34'(s1_a2);
            for (int s = 0; s < RED_ST; s++)
                for (int l = 0; l < 2; l++)
                    red_reg[s+1][l] <= red_next[s][l];
            for (int l = 0; l < 2; l++)
                cor_reg[0][l] <= cor_init[l];
            for (int s = 0; s < COR_ST; s++)
                for (int l = 0; l < 2; l++)
                    cor_reg[s+1][l] <= cor_next[s][l];
        end
    end

    // ------------------------------------------------------------------
    // Valid chain and output register
    // ------------------------------------------------------------------
    logic [4:0]         out_row_reg, out_col_reg;
    logic signed [31:0] new_position_reg, new_velocity_reg, step_time_reg;
    logic               sweep_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // drop out-of-lattice loads at the door
            vld_reg          <= {vld_reg[NST-1:1], acc && (entry.upd || in_range)};
            result_valid_reg <= vld_reg[NST] && pipe_reg[NST].upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg      <= 5'(pipe_reg[NST].row);
            out_col_reg      <= 5'(pipe_reg[NST].col);
            new_position_reg <= pipe_reg[NST].nq;
            new_velocity_reg <= s20_nv;
            step_time_reg    <= pipe_reg[NST].used;
            sweep_last_reg   <= pipe_reg[NST].last;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign new_position = new_position_reg;
    assign new_velocity = new_velocity_reg;
    assign step_time    = step_time_reg;
    assign sweep_last   = sweep_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LLSU_ASSERT_IMP(a_no_update_behind_hazard, vld_reg[1] && pipe_reg[1].upd, !haz_older)
    `LLSU_ASSERT_NEXT(a_bank_swaps_on_last, acc && entry.upd && entry.last,
                      bank_select_reg != $past(bank_select_reg))
    `LLSU_ASSERT_NEXT(a_update_gives_result, adv && vld_reg[NST] && pipe_reg[NST].upd,
                      result_valid_reg)

endmodule
`default_nettype wire
